>>> rtl/core/rarm_pkg.sv
// ----------------------------------------------------------------------------
// rarm_pkg
// shared widths and operation codes of the range add / range max store
// ----------------------------------------------------------------------------
`default_nettype none
package rarm_pkg;
  localparam int unsigned POS_W = 11;
  localparam int unsigned VAL_W = 32;
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic [POS_W-1:0] COUNT_RESET = 11'd1024;
endpackage
`default_nettype wire

>>> rtl/core/range_add_range_max_store.sv
// ----------------------------------------------------------------------------
// range_add_range_max_store
// array of signed 32-bit values with range add and range maximum requests
// ----------------------------------------------------------------------------
// channel  | ports                                         | handshake
// input    | in_kind in_range_low in_range_high in_add_amount | start & !busy
// result   | out_range_maximum out_range_error             | out_valid, 1 cycle
// config   | cfg_data                                      | cfg_valid & cfg_ready
//
// a valid request walks the positions from low to high with one shared
// adder/compare: one memory read and one write or compare per position.
// an invalid request leaves the block idle. after reset a clearing pass
// over all positions holds busy high. the receiver cannot stall; config is
// always ready.
`default_nettype none
module range_add_range_max_store #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_kind,
  input  wire logic [rarm_pkg::POS_W-1:0]        in_range_low,
  input  wire logic [rarm_pkg::POS_W-1:0]        in_range_high,
  input  wire logic signed [rarm_pkg::VAL_W-1:0] in_add_amount,
  output logic                                   out_valid,
  output logic signed [rarm_pkg::VAL_W-1:0]      out_range_maximum,
  output logic                                   out_range_error,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rarm_pkg::POS_W-1:0]        cfg_data
);
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW0 = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CW = (CW0 > rarm_pkg::POS_W) ? CW0 : rarm_pkg::POS_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_ELEMENTS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CLEAR, ST_RD, ST_EXEC} state_t;

  state_t state_r;
  logic [rarm_pkg::POS_W-1:0] count_r, lo_r, hi_r, pos_r;
  logic [AW-1:0] clr_r;
  logic kind_r;
  logic [rarm_pkg::VAL_W-1:0] amt_r, best_r, rd_data_r;
  logic out_valid_r, out_error_r;
  logic [rarm_pkg::VAL_W-1:0] out_max_r;
  logic [rarm_pkg::VAL_W-1:0] mem [MAX_ELEMENTS];

  logic [CW-1:0] cnt_eff, hi_x;
  logic req_ok, accept, first, bigger, res_fire;
  logic [AW-1:0] addr;
  logic [rarm_pkg::VAL_W-1:0] sum;

  always_comb begin
    cnt_eff = (CW'(count_r) > MAX_C) ? MAX_C : CW'(count_r);
    hi_x = CW'(in_range_high);
    req_ok = (in_range_low != '0) && (in_range_low <= in_range_high) && (hi_x <= cnt_eff);
    accept = start && (state_r == ST_IDLE);
    addr = (state_r == ST_CLEAR) ? clr_r : AW'(pos_r - 1'b1);
    sum = rd_data_r + amt_r;
    first = (pos_r == lo_r);
    bigger = $signed(rd_data_r) > $signed(best_r);
    // a result leaves on a rejected query or at the last position of a query
    res_fire = (accept && !req_ok && in_kind == rarm_pkg::KIND_QUERY) ||
               (state_r == ST_EXEC && pos_r == hi_r && kind_r == rarm_pkg::KIND_QUERY);
  end

  // shared memory port: registered read, one write
  always_ff @(posedge clk) begin
    rd_data_r <= mem[addr];
    if (state_r == ST_CLEAR) begin
      mem[addr] <= '0;
    end else if (state_r == ST_EXEC && kind_r == rarm_pkg::KIND_ADD) begin
      mem[addr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= rarm_pkg::COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_fire;
      if (cfg_valid) begin
        count_r <= cfg_data;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_A) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            kind_r <= in_kind;
            lo_r   <= in_range_low;
            hi_r   <= in_range_high;
            pos_r  <= in_range_low;
            amt_r  <= in_add_amount;
            if (req_ok) begin
              state_r <= ST_RD;
            end else if (in_kind == rarm_pkg::KIND_QUERY) begin
              out_max_r   <= '0;
              out_error_r <= 1'b1;
            end
          end
        end
        ST_RD: state_r <= ST_EXEC;
        ST_EXEC: begin
          if (kind_r == rarm_pkg::KIND_QUERY && (first || bigger)) best_r <= rd_data_r;
          if (pos_r == hi_r) begin
            state_r <= ST_IDLE;
            if (kind_r == rarm_pkg::KIND_QUERY) begin
              out_max_r   <= (first || bigger) ? rd_data_r : best_r;
              out_error_r <= 1'b0;
            end
          end else begin
            pos_r   <= pos_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_range_maximum = out_max_r;
  assign out_range_error = out_error_r;
endmodule
`default_nettype wire

>>> rtl/core/rarm_checker.sv
// ----------------------------------------------------------------------------
// rarm_checker
// port level checks of the range add / range max store
// ----------------------------------------------------------------------------
`default_nettype none
module rarm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_kind,
  input wire logic [10:0] in_range_low,
  input wire logic        out_valid,
  input wire logic [31:0] out_range_maximum,
  input wire logic        out_range_error
);
  // clearing pass follows reset
  a_clear: assert property (@(posedge clk) !rst_n |=> busy) else $error("no clear");
  // adds never give a result
  a_add: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == rarm_pkg::KIND_ADD |=> !out_valid) else $error("add result");
  // error results carry zero
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_range_maximum == '0) else $error("err value");
  // a query from position zero fails at once
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == rarm_pkg::KIND_QUERY && in_range_low == '0
    |=> out_valid && out_range_error) else $error("zero low");
endmodule

bind range_add_range_max_store rarm_checker u_rarm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_kind(in_kind),
  .in_range_low(in_range_low), .out_valid(out_valid),
  .out_range_maximum(out_range_maximum), .out_range_error(out_range_error)
);
`default_nettype wire

>>> tb/range_max_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_max_checker
// watches the request, result and count-write channels of the range store,
// keeps a plain array model of the values and compares every query result
// ----------------------------------------------------------------------------
module range_max_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic                              in_kind,
  input  wire logic [rarm_pkg::POS_W-1:0]        in_range_low,
  input  wire logic [rarm_pkg::POS_W-1:0]        in_range_high,
  input  wire logic signed [rarm_pkg::VAL_W-1:0] in_add_amount,
  input  wire logic                              out_valid,
  input  wire logic signed [rarm_pkg::VAL_W-1:0] out_range_maximum,
  input  wire logic                              out_range_error,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic [rarm_pkg::POS_W-1:0]        cfg_data,
  output int                                     fail_count,
  output int                                     pending_results,
  output int                                     query_count,
  output int                                     error_count
);
  localparam int unsigned CAPACITY = 1024;

  typedef struct packed {
    logic signed [rarm_pkg::VAL_W-1:0] maximum;
    logic                              error;
  } range_result_t;

  logic signed [rarm_pkg::VAL_W-1:0] element_value [1:CAPACITY];
  logic [rarm_pkg::POS_W-1:0]        count_reg;
  range_result_t                     expected_results [$];

  assign pending_results = expected_results.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // executes one request on the array model, returns 1 when a result is due
  function automatic bit apply_request(input logic kind,
                                       input logic [rarm_pkg::POS_W-1:0] lo,
                                       input logic [rarm_pkg::POS_W-1:0] hi,
                                       input logic signed [rarm_pkg::VAL_W-1:0] amount,
                                       output range_result_t res);
    int unsigned limit;
    bit ok;
    limit = (count_reg > CAPACITY) ? CAPACITY : count_reg;
    ok = lo >= 1 && lo <= hi && hi <= limit;
    res = '{maximum: '0, error: !ok};
    if (kind == rarm_pkg::KIND_ADD) begin
      if (ok) for (int p = lo; p <= hi; p++) element_value[p] += amount;
      return 0;
    end
    if (ok) begin
      res.maximum = element_value[lo];
      for (int p = lo + 1; p <= hi; p++)
        if (element_value[p] > res.maximum) res.maximum = element_value[p];
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    range_result_t res;
    range_result_t want;
    if (!rst_n) begin
      for (int p = 1; p <= CAPACITY; p++) element_value[p] = '0;
      count_reg = rarm_pkg::COUNT_RESET;
      expected_results.delete();
      fail_count = 0;
      query_count = 0;
      error_count = 0;
    end else begin
      // results leave before a new request can be accepted in the same edge
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result max=%0d err=%0b",
                           out_range_maximum, out_range_error));
        end else begin
          want = expected_results.pop_front();
          if (out_range_error !== want.error)
            report($sformatf("error flag %0b, want %0b", out_range_error, want.error));
          if (out_range_maximum !== want.maximum)
            report($sformatf("maximum %0d, want %0d", out_range_maximum, want.maximum));
        end
      end
      if (start && !busy) begin
        if (apply_request(in_kind, in_range_low, in_range_high, in_add_amount, res)) begin
          expected_results.push_back(res);
          query_count++;
          if (res.error) error_count++;
        end
      end
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
    end
  end
endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// range add / range max store: directed corners, random requests under
// several element counts, random idle bursts on the request side
// ----------------------------------------------------------------------------
module tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = rarm_pkg::KIND_ADD;
  logic [rarm_pkg::POS_W-1:0] in_range_low = '0;
  logic [rarm_pkg::POS_W-1:0] in_range_high = '0;
  logic signed [rarm_pkg::VAL_W-1:0] in_add_amount = '0;
  logic out_valid;
  logic signed [rarm_pkg::VAL_W-1:0] out_range_maximum;
  logic out_range_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rarm_pkg::POS_W-1:0] cfg_data = '0;
  int fail_count, pending_results, query_count, error_count;
  bit idle_on = 1'b1;
  logic [rarm_pkg::POS_W-1:0] active_count = rarm_pkg::COUNT_RESET;

  always #6 clk = ~clk;

  range_add_range_max_store i_dut (.*);

  range_max_checker i_checker (.*);

  // drives one request and holds it until accepted
  task automatic send_request(input logic kind, input int lo, input int hi,
                              input logic signed [rarm_pkg::VAL_W-1:0] amount);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_range_low <= lo[rarm_pkg::POS_W-1:0];
    in_range_high <= hi[rarm_pkg::POS_W-1:0];
    in_add_amount <= amount;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_count(input logic [rarm_pkg::POS_W-1:0] value);
    start <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_count = value;
  endtask

  function automatic logic signed [rarm_pkg::VAL_W-1:0] random_amount();
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 20)) - 10;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic random_request();
    int lim, lo, hi, span;
    logic kind;
    lim = (active_count == '0) ? 1 :
          ((int'(active_count) > 1024) ? 1024 : int'(active_count));
    kind = 1'($urandom_range(0, 1));
    // short ranges keep the walk quick; a few span all active positions
    span = ($urandom_range(0, 19) == 0) ? lim : $urandom_range(1, (lim < 24) ? lim : 24);
    lo = $urandom_range(1, lim - span + 1);
    hi = lo + span - 1;
    case ($urandom_range(0, 19))
      0: lo = 0;
      1: begin lo = hi + 1; end
      2: hi = lim + $urandom_range(1, 3);
      3: begin lo = $urandom(); hi = $urandom(); end
      default: ;
    endcase
    send_request(kind, lo & 'h7ff, hi & 'h7ff, random_amount());
  endtask

  initial begin
    logic [rarm_pkg::POS_W-1:0] counts [5] = '{11'd1, 11'd2047, 11'd0, 11'd37, 11'd1024};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed corners
    send_request(rarm_pkg::KIND_QUERY, 1, 1024, 0);
    send_request(rarm_pkg::KIND_ADD, 1, 1024, 32'sh7fffffff);
    send_request(rarm_pkg::KIND_ADD, 5, 5, 1);
    send_request(rarm_pkg::KIND_QUERY, 1, 1024, 0);
    send_request(rarm_pkg::KIND_QUERY, 4, 6, 0);
    send_request(rarm_pkg::KIND_ADD, 1024, 1024, 32'sh80000000);
    send_request(rarm_pkg::KIND_QUERY, 1020, 1024, 0);
    send_request(rarm_pkg::KIND_QUERY, 0, 3, 0);
    send_request(rarm_pkg::KIND_ADD, 0, 3, 100);
    send_request(rarm_pkg::KIND_QUERY, 9, 8, 0);
    send_request(rarm_pkg::KIND_ADD, 9, 8, 100);
    send_request(rarm_pkg::KIND_QUERY, 1, 1025, 0);
    send_request(rarm_pkg::KIND_QUERY, 2047, 2047, 0);
    send_request(rarm_pkg::KIND_ADD, 3, 3, -7);
    send_request(rarm_pkg::KIND_QUERY, 3, 3, 0);
    send_request(rarm_pkg::KIND_QUERY, 1, 10, 0);
    for (int ph = 0; ph < 5; ph++) begin
      write_count(counts[ph]);
      send_request(rarm_pkg::KIND_QUERY, 1, int'(counts[ph]), 0);
      for (int n = 0; n < 125; n++) begin
        if (ph == 4 && n == 90) idle_on = 1'b0;
        random_request();
      end
    end
    start <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
    $display("covered %0d queries (%0d with bad ranges) over counts 1, 2047, 0, 37, 1024",
             query_count, error_count);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #100ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
